// File: rtl/core/qfpc_pkg.sv
// Package for the qualified flow pulse counter: item and result types,
// controller/datapath command and status structs, register indexes and constants.
// Depends on nothing.
package qfpc_pkg;

    localparam int unsigned NUM_PORTS = 2;

    localparam int unsigned SEC_W  = 32;
    localparam int unsigned SS_W   = 15;
    localparam int unsigned MODE_W = 2;
    localparam int unsigned MINW_W = 16;
    localparam int unsigned CNT_W  = 32;

    // Configuration port.
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_MODE_PORT0 = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MODE_PORT1 = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PRESCALER  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_WIDTH  = 2'd3;

    localparam logic [MODE_W-1:0] MODE_PWM_DIR = 2'd0;
    localparam logic [MODE_W-1:0] MODE_PWM     = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FWD_REV = 2'd2;

    localparam logic [SS_W-1:0]   PRESCALER_RESET = 15'd255;
    localparam logic [MINW_W-1:0] MIN_WIDTH_RESET = 16'd50;

    // Pin codes in the item.
    localparam logic PIN_PWM = 1'b0;
    localparam logic PIN_DIR = 1'b1;

    // Subsecond conversion: numerator 1000 * (P - ss) fits in 25 bits,
    // the divisor P + 1 in 16 bits, and the quotient stays below 1000.
    localparam int unsigned MS_W  = 10;
    localparam int unsigned NUM_W = 25;
    localparam int unsigned DIV_W = 16;
    localparam int unsigned QUO_W = 10;
    localparam int unsigned STEP_W = 4;

    localparam logic [MS_W-1:0]  MS_PER_SEC     = 10'd1000;
    localparam logic [CNT_W-1:0] MS_PER_SEC_W32 = 32'd1000;

    typedef struct packed {
        logic [0:0]      port;
        logic            mode;
        logic            pwm_high;
        logic            dir_high;
        logic [SEC_W-1:0] time_seconds;
        logic [SS_W-1:0]  time_subseconds;
    } qfpc_in_t;

    typedef struct packed {
        logic [CNT_W-1:0] forward_count;
        logic [CNT_W-1:0] reverse_count;
        logic [CNT_W-1:0] pulse_width_ms;
        logic             save_request;
        logic             pulse_rejected;
    } qfpc_out_t;

    typedef struct packed {
        logic load_item;
        logic div_start;
        logic div_sel_start;
        logic cap_f_end;
        logic cap_f_start;
        logic calc_width;
        logic commit;
    } qfpc_cmd_t;

    typedef struct packed {
        logic need_width;
        logic div_done;
        logic out_free;
    } qfpc_sts_t;

endpackage

// File: rtl/core/qfpc_div.sv
// Iterative divider for the subsecond-to-millisecond conversion.
// Produces a ten-bit quotient, one bit per cycle. Depends on qfpc_pkg.
module qfpc_div
    import qfpc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] numerator,
    input  logic [DIV_W-1:0] divisor,
    output logic             done,
    output logic [QUO_W-1:0] quotient
);

    logic [NUM_W-1:0]  rem_reg, rem_next;
    logic [NUM_W-1:0]  dsh_reg, dsh_next;
    logic [QUO_W-1:0]  quo_reg, quo_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic              fits;

    // The quotient is known to stay below 2^QUO_W, so the trial divisor
    // starts at divisor << (QUO_W-1) and halves every cycle.
    assign fits = (rem_reg >= dsh_reg);

    always_comb
    begin
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        quo_next  = quo_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = numerator;
            dsh_next  = {divisor, {(QUO_W-1){1'b0}}};
            quo_next  = '0;
            step_next = STEP_W'(QUO_W - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_next = rem_reg - dsh_reg;
            end
            quo_next = {quo_reg[QUO_W-2:0], fits};
            dsh_next = dsh_reg >> 1;
            if (step_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                step_next = step_reg - STEP_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsh_reg <= dsh_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// File: rtl/core/qfpc_dp.sv
// Datapath of the qualified flow pulse counter: configuration registers,
// per-port pulse state and counters, width arithmetic and the result register.
// Depends on qfpc_pkg and qfpc_div.
module qfpc_dp
    import qfpc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  qfpc_cmd_t             cmd,
    output qfpc_sts_t             sts,
    input  qfpc_in_t              ev_data,
    output qfpc_out_t             res_data,
    output logic                  res_valid,
    input  logic                  res_ready,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // Configuration.
    logic [MODE_W-1:0] mode0_reg, mode1_reg;
    logic [SS_W-1:0]   presc_reg;
    logic [MINW_W-1:0] minw_reg;

    // Per-port state.
    logic             pwm_act_reg [NUM_PORTS];
    logic             dir_act_reg [NUM_PORTS];
    logic [SEC_W-1:0] pwm_s_reg   [NUM_PORTS];
    logic [SS_W-1:0]  pwm_ss_reg  [NUM_PORTS];
    logic [SEC_W-1:0] dir_s_reg   [NUM_PORTS];
    logic [SS_W-1:0]  dir_ss_reg  [NUM_PORTS];
    logic [CNT_W-1:0] fwd_reg     [NUM_PORTS];
    logic [CNT_W-1:0] rev_reg     [NUM_PORTS];
    logic [CNT_W-1:0] width_reg   [NUM_PORTS];

    qfpc_in_t         item_reg;
    logic [QUO_W-1:0] f_end_reg, f_start_reg;
    logic [CNT_W-1:0] w_reg;
    qfpc_out_t        res_reg;
    logic             res_valid_reg;

    logic [0:0]        p;
    logic              port_ok;
    logic [MODE_W-1:0] mm;
    logic              pwm_rise, pwm_fall, dir_rise, dir_fall;
    logic [SEC_W-1:0]  start_s;
    logic [SS_W-1:0]   start_ss;
    logic [SS_W-1:0]   ss_sel, ss_clamp;
    logic [NUM_W-1:0]  div_num;
    logic [DIV_W-1:0]  div_den;
    logic              div_done;
    logic [QUO_W-1:0]  div_quo;
    logic [CNT_W-1:0]  w_next;
    logic              qualified;
    logic              new_pwm_act, new_dir_act;
    logic [CNT_W-1:0]  new_fwd, new_rev, new_width;
    logic              save, rej;
    qfpc_out_t         res_next;

    assign p       = item_reg.port;
    assign port_ok = (32'(item_reg.port) < 32'(NUM_PORTS));
    assign mm      = (item_reg.port == 1'b1) ? mode1_reg : mode0_reg;

    always_comb
    begin
        pwm_rise = (item_reg.mode == PIN_PWM) && item_reg.pwm_high;
        pwm_fall = (item_reg.mode == PIN_PWM) && !item_reg.pwm_high && pwm_act_reg[p];
        dir_rise = (item_reg.mode == PIN_DIR) && (mm == MODE_FWD_REV) && item_reg.dir_high;
        dir_fall = (item_reg.mode == PIN_DIR) && (mm == MODE_FWD_REV)
                   && !item_reg.dir_high && dir_act_reg[p];
        start_s  = pwm_fall ? pwm_s_reg[p]  : dir_s_reg[p];
        start_ss = pwm_fall ? pwm_ss_reg[p] : dir_ss_reg[p];
    end

    // Subsecond to milliseconds: 1000 * (P - ss) / (P + 1), with ss clamped to at most P.
    assign ss_sel   = cmd.div_sel_start ? start_ss : item_reg.time_subseconds;
    assign ss_clamp = (ss_sel > presc_reg) ? presc_reg : ss_sel;
    assign div_num  = NUM_W'(MS_PER_SEC) * NUM_W'(presc_reg - ss_clamp);
    assign div_den  = DIV_W'(presc_reg) + DIV_W'(1);

    qfpc_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .numerator (div_num),
        .divisor   (div_den),
        .done      (div_done),
        .quotient  (div_quo)
    );

    assign w_next = (item_reg.time_seconds - start_s) * MS_PER_SEC_W32
                    + CNT_W'(f_end_reg) - CNT_W'(f_start_reg);

    assign qualified = (w_reg > CNT_W'(minw_reg));

    always_comb
    begin
        new_pwm_act = pwm_act_reg[p];
        new_dir_act = dir_act_reg[p];
        new_fwd     = fwd_reg[p];
        new_rev     = rev_reg[p];
        new_width   = width_reg[p];
        save        = 1'b0;
        rej         = 1'b0;
        if (pwm_rise || dir_rise)
        begin
            new_pwm_act = pwm_rise;
            new_dir_act = dir_rise;
        end
        else if (pwm_fall)
        begin
            new_pwm_act = 1'b0;
            new_dir_act = 1'b0;
            new_width   = w_reg;
            if (qualified)
            begin
                save = 1'b1;
                if (mm == MODE_PWM_DIR)
                begin
                    if (item_reg.dir_high)
                    begin
                        new_fwd = fwd_reg[p] + CNT_W'(1);
                    end
                    else if (fwd_reg[p] != '0)
                    begin
                        new_fwd = fwd_reg[p] - CNT_W'(1);
                    end
                    new_rev = '0;
                end
                else if (mm == MODE_PWM)
                begin
                    new_fwd = fwd_reg[p] + CNT_W'(1);
                    new_rev = '0;
                end
                else
                begin
                    new_fwd = fwd_reg[p] + CNT_W'(1);
                end
            end
            else
            begin
                rej = 1'b1;
            end
        end
        else if (dir_fall)
        begin
            save        = 1'b1;
            new_pwm_act = 1'b0;
            new_dir_act = 1'b0;
            new_width   = w_reg;
            if (qualified)
            begin
                new_rev = rev_reg[p] + CNT_W'(1);
            end
            else
            begin
                rej = 1'b1;
            end
        end

        // An item for a port that does not exist reports all zeros.
        if (port_ok)
        begin
            res_next.forward_count  = new_fwd;
            res_next.reverse_count  = new_rev;
            res_next.pulse_width_ms = new_width;
            res_next.save_request   = save;
            res_next.pulse_rejected = rej;
        end
        else
        begin
            res_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode0_reg <= MODE_PWM_DIR;
            mode1_reg <= MODE_PWM_DIR;
            presc_reg <= PRESCALER_RESET;
            minw_reg  <= MIN_WIDTH_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MODE_PORT0: mode0_reg <= cfg_data[MODE_W-1:0];
                REG_MODE_PORT1: mode1_reg <= cfg_data[MODE_W-1:0];
                REG_PRESCALER:  presc_reg <= cfg_data[SS_W-1:0];
                REG_MIN_WIDTH:  minw_reg  <= cfg_data[MINW_W-1:0];
                default:        mode0_reg <= mode0_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_PORTS; i++)
            begin
                pwm_act_reg[i] <= 1'b0;
                dir_act_reg[i] <= 1'b0;
                pwm_s_reg[i]   <= '0;
                pwm_ss_reg[i]  <= '0;
                dir_s_reg[i]   <= '0;
                dir_ss_reg[i]  <= '0;
                fwd_reg[i]     <= '0;
                rev_reg[i]     <= '0;
                width_reg[i]   <= '0;
            end
        end
        else if (cmd.commit && port_ok)
        begin
            pwm_act_reg[p] <= new_pwm_act;
            dir_act_reg[p] <= new_dir_act;
            fwd_reg[p]     <= new_fwd;
            rev_reg[p]     <= new_rev;
            width_reg[p]   <= new_width;
            if (pwm_rise)
            begin
                pwm_s_reg[p]  <= item_reg.time_seconds;
                pwm_ss_reg[p] <= item_reg.time_subseconds;
            end
            if (dir_rise)
            begin
                dir_s_reg[p]  <= item_reg.time_seconds;
                dir_ss_reg[p] <= item_reg.time_subseconds;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            item_reg <= ev_data;
        end
        if (cmd.cap_f_end)
        begin
            f_end_reg <= div_quo;
        end
        if (cmd.cap_f_start)
        begin
            f_start_reg <= div_quo;
        end
        if (cmd.calc_width)
        begin
            w_reg <= w_next;
        end
        if (cmd.commit)
        begin
            res_reg <= res_next;
        end
    end

    assign sts.need_width = port_ok && (pwm_fall || dir_fall);
    assign sts.div_done   = div_done;
    assign sts.out_free   = !res_valid_reg || res_ready;

    assign res_data  = res_reg;
    assign res_valid = res_valid_reg;

endmodule

// File: rtl/core/qfpc_ctrl.sv
// Controller of the qualified flow pulse counter: sequences item capture,
// the two subsecond divisions, the width step and the commit. Depends on qfpc_pkg.
module qfpc_ctrl
    import qfpc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      ev_valid,
    output logic      ev_ready,
    input  qfpc_sts_t sts,
    output qfpc_cmd_t cmd
);

    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_DECIDE    = 3'd1;
    localparam logic [2:0] S_DIV_END   = 3'd2;
    localparam logic [2:0] S_DIV_START = 3'd3;
    localparam logic [2:0] S_WIDTH     = 3'd4;
    localparam logic [2:0] S_COMMIT    = 3'd5;

    logic [2:0] state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (ev_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (sts.need_width)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV_END;
                end
                else
                begin
                    state_next = S_COMMIT;
                end
            end
            S_DIV_END:
            begin
                if (sts.div_done)
                begin
                    cmd.cap_f_end     = 1'b1;
                    cmd.div_start     = 1'b1;
                    cmd.div_sel_start = 1'b1;
                    state_next        = S_DIV_START;
                end
            end
            S_DIV_START:
            begin
                if (sts.div_done)
                begin
                    cmd.cap_f_start = 1'b1;
                    state_next      = S_WIDTH;
                end
            end
            S_WIDTH:
            begin
                cmd.calc_width = 1'b1;
                state_next     = S_COMMIT;
            end
            S_COMMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign ev_ready = (state_reg == S_IDLE);

endmodule

// File: rtl/core/qualified_flow_pulse_counter.sv
// Top level of the qualified flow pulse counter for water-meter input ports.
// Joins the controller and the datapath. Depends on qfpc_pkg, qfpc_ctrl and qfpc_dp.
//
//   channel   handshake                    payload
//   event     ev_valid / ev_ready          ev_data   (qfpc_in_t)
//   result    res_valid / res_ready        res_data  (qfpc_out_t)
//   config    cfg_we                       cfg_index, cfg_data
//
// An item that ends an armed pulse goes through the states DIV_END, DIV_START and
// WIDTH: two ten-step divisions on the one shared divider, then the width step.
// Any other item goes from DECIDE straight to COMMIT. One item is in work
// at a time; the next item can be taken the cycle after the result is written.
// The result register holds a finished item while the next one is taken in;
// a further item waits in the commit step until the result has been taken.
// Reset clears configuration to its defaults and all per-port state at once.
module qualified_flow_pulse_counter
    import qfpc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  ev_valid,
    output logic                  ev_ready,
    input  qfpc_in_t              ev_data,
    output logic                  res_valid,
    input  logic                  res_ready,
    output qfpc_out_t             res_data,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    qfpc_cmd_t cmd;
    qfpc_sts_t sts;

    qfpc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .ev_valid (ev_valid),
        .ev_ready (ev_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    qfpc_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .ev_data   (ev_data),
        .res_data  (res_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule

// File: bench/qualified_flow_pulse_counter_tb.sv
// Testbench for qualified_flow_pulse_counter: a queue-fed driver, a checking monitor and an
// item-level predictor of the per-port pulse timing and counting.
// Depends on qfpc_pkg and the qualified_flow_pulse_counter RTL.
module qualified_flow_pulse_counter_tb;
    import qfpc_pkg::*;

    // Code 3 is outside the documented modes: pwm pulses count forward only.
    localparam logic [MODE_W-1:0] MODE_FWD_ONLY = 2'd3;
    localparam int STALL_LIMIT = 2000;
    localparam int REPORT_LIMIT = 10;

    logic                  clk;
    logic                  rst_n;
    logic                  ev_valid;
    logic                  ev_ready;
    qfpc_in_t              ev_data;
    logic                  res_valid;
    logic                  res_ready;
    qfpc_out_t             res_data;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    qualified_flow_pulse_counter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .ev_valid  (ev_valid),
        .ev_ready  (ev_ready),
        .ev_data   (ev_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    qfpc_in_t  events_to_send [$];
    qfpc_out_t counts_due [$];
    int        ev_idle_pct;
    int        res_idle_pct;
    int        bad_results;
    int        stall_cycles;

    // Predictor copy of configuration and per-port state.
    logic [MODE_W-1:0] port_mode [NUM_PORTS];
    logic [SS_W-1:0]   prescale;
    logic [MINW_W-1:0] min_width;
    logic              pwm_armed [NUM_PORTS];
    logic              dir_armed [NUM_PORTS];
    logic [SEC_W-1:0]  pwm_t0_sec [NUM_PORTS];
    logic [SS_W-1:0]   pwm_t0_sub [NUM_PORTS];
    logic [SEC_W-1:0]  dir_t0_sec [NUM_PORTS];
    logic [SS_W-1:0]   dir_t0_sub [NUM_PORTS];
    logic [CNT_W-1:0]  fwd_total [NUM_PORTS];
    logic [CNT_W-1:0]  rev_total [NUM_PORTS];
    logic [CNT_W-1:0]  width_seen [NUM_PORTS];

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Milliseconds elapsed within the second for a down-counting subsecond value.
    function automatic logic [31:0] sub_ms(input logic [SS_W-1:0] ss);
        logic [31:0] p;
        logic [31:0] s;
        p = 32'(prescale);
        s = 32'(ss);
        if (s > p)
            s = p;
        return (32'd1000 * (p - s)) / (p + 32'd1);
    endfunction

    function automatic logic [31:0] pulse_ms(input logic [31:0] s0, input logic [SS_W-1:0] ss0,
                                             input logic [31:0] s1, input logic [SS_W-1:0] ss1);
        logic [31:0] w;
        w = (s1 - s0) * 32'd1000;
        w = w + sub_ms(ss1) - sub_ms(ss0);
        return w;
    endfunction

    function automatic qfpc_out_t count_event(input qfpc_in_t ev);
        qfpc_out_t   r;
        logic [31:0] w;
        logic [1:0]  mm;
        int          p;
        r = '0;
        p = int'(ev.port);
        mm = port_mode[p];
        if (ev.mode == PIN_PWM)
        begin
            if (ev.pwm_high)
            begin
                pwm_t0_sec[p] = ev.time_seconds;
                pwm_t0_sub[p] = ev.time_subseconds;
                pwm_armed[p] = 1'b1;
                dir_armed[p] = 1'b0;
            end
            else if (pwm_armed[p])
            begin
                pwm_armed[p] = 1'b0;
                dir_armed[p] = 1'b0;
                w = pulse_ms(pwm_t0_sec[p], pwm_t0_sub[p], ev.time_seconds, ev.time_subseconds);
                width_seen[p] = w;
                if (w > {16'd0, min_width})
                begin
                    r.save_request = 1'b1;
                    if (mm == MODE_PWM_DIR)
                    begin
                        if (ev.dir_high)
                            fwd_total[p] = fwd_total[p] + 1;
                        else if (fwd_total[p] != 0)
                            fwd_total[p] = fwd_total[p] - 1;
                        rev_total[p] = '0;
                    end
                    else if (mm == MODE_PWM)
                    begin
                        fwd_total[p] = fwd_total[p] + 1;
                        rev_total[p] = '0;
                    end
                    else
                        fwd_total[p] = fwd_total[p] + 1;
                end
                else
                    r.pulse_rejected = 1'b1;
            end
        end
        else if (mm == MODE_FWD_REV)
        begin
            if (ev.dir_high)
            begin
                dir_t0_sec[p] = ev.time_seconds;
                dir_t0_sub[p] = ev.time_subseconds;
                dir_armed[p] = 1'b1;
                pwm_armed[p] = 1'b0;
            end
            else if (dir_armed[p])
            begin
                r.save_request = 1'b1;
                pwm_armed[p] = 1'b0;
                dir_armed[p] = 1'b0;
                w = pulse_ms(dir_t0_sec[p], dir_t0_sub[p], ev.time_seconds, ev.time_subseconds);
                width_seen[p] = w;
                if (w > {16'd0, min_width})
                    rev_total[p] = rev_total[p] + 1;
                else
                    r.pulse_rejected = 1'b1;
            end
        end
        r.forward_count = fwd_total[p];
        r.reverse_count = rev_total[p];
        r.pulse_width_ms = width_seen[p];
        return r;
    endfunction

    // Driver: a new item is offered only once the previous one has been taken.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (ev_valid && ev_ready)
                counts_due.push_back(count_event(ev_data));
            if (!ev_valid || ev_ready)
            begin
                if (events_to_send.size() != 0 && $urandom_range(99) >= ev_idle_pct)
                begin
                    ev_valid <= 1'b1;
                    ev_data <= events_to_send.pop_front();
                end
                else
                    ev_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin : result_monitor
        qfpc_out_t want;
        if (rst_n)
        begin
            if (res_valid && res_ready)
            begin
                if (counts_due.size() == 0)
                begin
                    bad_results = bad_results + 1;
                    if (bad_results <= REPORT_LIMIT)
                        $display("unexpected result at %0t: fwd %0d rev %0d width %0d",
                                 $realtime, res_data.forward_count, res_data.reverse_count,
                                 res_data.pulse_width_ms);
                end
                else
                begin
                    want = counts_due.pop_front();
                    if (res_data.forward_count !== want.forward_count
                        || res_data.reverse_count !== want.reverse_count
                        || res_data.pulse_width_ms !== want.pulse_width_ms
                        || res_data.save_request !== want.save_request
                        || res_data.pulse_rejected !== want.pulse_rejected)
                    begin
                        bad_results = bad_results + 1;
                        if (bad_results <= REPORT_LIMIT)
                            $display({"mismatch at %0t (got/expected): fwd %0d/%0d rev %0d/%0d",
                                      " width %0d/%0d save %0b/%0b rej %0b/%0b"},
                                     $realtime, res_data.forward_count, want.forward_count,
                                     res_data.reverse_count, want.reverse_count,
                                     res_data.pulse_width_ms, want.pulse_width_ms,
                                     res_data.save_request, want.save_request,
                                     res_data.pulse_rejected, want.pulse_rejected);
                    end
                end
            end
            res_ready <= ($urandom_range(99) >= res_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((ev_valid && ev_ready) || (res_valid && res_ready))
                stall_cycles <= 0;
            else if (stall_cycles >= STALL_LIMIT)
            begin
                $display("== FAIL ==");
                $finish;
            end
            else
                stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic queue_event(input logic p, input logic pin, input logic pwm, input logic dir,
                               input logic [SEC_W-1:0] s, input logic [SS_W-1:0] ss);
        qfpc_in_t ev;
        ev.port = p;
        ev.mode = pin;
        ev.pwm_high = pwm;
        ev.dir_high = dir;
        ev.time_seconds = s;
        ev.time_subseconds = ss;
        events_to_send.push_back(ev);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            REG_MODE_PORT0: port_mode[0] = val[MODE_W-1:0];
            REG_MODE_PORT1: port_mode[1] = val[MODE_W-1:0];
            REG_PRESCALER:  prescale = val[SS_W-1:0];
            REG_MIN_WIDTH:  min_width = val[MINW_W-1:0];
            default: ;
        endcase
    endtask

    // Upper data bits beyond each register's width are filled with noise.
    task automatic program_regs(input logic [MODE_W-1:0] m0, input logic [MODE_W-1:0] m1,
                                input logic [SS_W-1:0] ps, input logic [MINW_W-1:0] mw);
        logic [CFG_DATA_W-1:0] junk;
        junk = CFG_DATA_W'($urandom);
        write_reg(REG_MODE_PORT0, {junk[15:2], m0});
        write_reg(REG_MODE_PORT1, {junk[13:0], m1});
        write_reg(REG_PRESCALER, {junk[15], ps});
        write_reg(REG_MIN_WIDTH, mw);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [SS_W-1:0] pick_subsec();
        logic [SS_W-1:0] ss;
        if ($urandom_range(9) == 0)
            ss = SS_W'($urandom_range(32767));
        else
            ss = SS_W'($urandom_range(prescale));
        return ss;
    endfunction

    // Moves a timestamp on; mostly by a width close to the minimum so that both
    // qualified and rejected pulses are common.
    task automatic step_time(inout logic [SEC_W-1:0] s, inout logic [SS_W-1:0] ss);
        longint unsigned period;
        longint unsigned ticks;
        longint unsigned cur;
        int              pick;
        pick = $urandom_range(99);
        period = 64'(prescale) + 64'd1;
        if (pick < 65)
        begin
            ticks = 64'($urandom_range(2 * min_width + 20));
            ticks = ticks * period / 1000;
            cur = (ss > prescale) ? 64'(prescale) : 64'(ss);
            if (ticks <= cur)
                ss = SS_W'(cur - ticks);
            else
            begin
                ticks = ticks - cur - 1;
                s = s + SEC_W'(1 + ticks / period);
                ss = SS_W'(64'(prescale) - (ticks % period));
            end
        end
        else if (pick < 90)
        begin
            s = s + $urandom_range(3);
            ss = pick_subsec();
        end
        else
        begin
            s = $urandom;
            ss = pick_subsec();
        end
    endtask

    task automatic queue_random_items(input int n);
        int               kind;
        logic             p;
        logic [SEC_W-1:0] s0;
        logic [SEC_W-1:0] s1;
        logic [SS_W-1:0]  ss0;
        logic [SS_W-1:0]  ss1;
        while (n > 0)
        begin
            kind = $urandom_range(99);
            p = ($urandom_range(1) != 0);
            s0 = $urandom;
            ss0 = pick_subsec();
            if (kind < 50)
            begin
                queue_event(p, PIN_PWM, 1'b1, $urandom_range(1) != 0, s0, ss0);
                step_time(s0, ss0);
                queue_event(p, PIN_PWM, 1'b0, $urandom_range(1) != 0, s0, ss0);
                n = n - 2;
            end
            else if (kind < 70)
            begin
                queue_event(p, PIN_DIR, $urandom_range(1) != 0, 1'b1, s0, ss0);
                step_time(s0, ss0);
                queue_event(p, PIN_DIR, $urandom_range(1) != 0, 1'b0, s0, ss0);
                n = n - 2;
            end
            else if (kind < 80)
            begin
                // Pulses on both ports overlapping in time.
                s1 = s0;
                ss1 = ss0;
                queue_event(p, PIN_PWM, 1'b1, 1'b1, s0, ss0);
                queue_event(!p, PIN_PWM, 1'b1, 1'b0, s1, ss1);
                step_time(s0, ss0);
                step_time(s1, ss1);
                queue_event(p, PIN_PWM, 1'b0, $urandom_range(1) != 0, s0, ss0);
                queue_event(!p, PIN_PWM, 1'b0, $urandom_range(1) != 0, s1, ss1);
                n = n - 4;
            end
            else if (kind < 88)
            begin
                // A dir pulse breaking into a pwm pulse on the same port.
                queue_event(p, PIN_PWM, 1'b1, 1'b0, s0, ss0);
                step_time(s0, ss0);
                queue_event(p, PIN_DIR, 1'b1, 1'b1, s0, ss0);
                step_time(s0, ss0);
                queue_event(p, PIN_PWM, 1'b0, 1'b1, s0, ss0);
                step_time(s0, ss0);
                queue_event(p, PIN_DIR, 1'b0, 1'b0, s0, ss0);
                n = n - 4;
            end
            else
            begin
                queue_event(p, $urandom_range(1) != 0, $urandom_range(1) != 0,
                            $urandom_range(1) != 0, s0, ss0);
                n = n - 1;
            end
        end
    endtask

    // Checked on the falling edge so that the driver's last update has settled.
    task automatic wait_for_drain();
        while (events_to_send.size() != 0 || ev_valid || counts_due.size() != 0)
            @(negedge clk);
    endtask

    task automatic run_phase(input logic [MODE_W-1:0] m0, input logic [MODE_W-1:0] m1,
                             input logic [SS_W-1:0] ps, input logic [MINW_W-1:0] mw,
                             input int idle, input int n);
        program_regs(m0, m1, ps, mw);
        ev_idle_pct = idle;
        res_idle_pct = idle;
        queue_random_items(n);
        wait_for_drain();
    endtask

    initial
    begin
        rst_n = 1'b0;
        ev_valid = 1'b0;
        ev_data = '0;
        res_ready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        bad_results = 0;
        stall_cycles = 0;
        ev_idle_pct = 21;
        res_idle_pct = 21;
        port_mode[0] = MODE_PWM_DIR;
        port_mode[1] = MODE_PWM_DIR;
        prescale = PRESCALER_RESET;
        min_width = MIN_WIDTH_RESET;
        for (int i = 0; i < NUM_PORTS; i++)
        begin
            pwm_armed[i] = 1'b0;
            dir_armed[i] = 1'b0;
            pwm_t0_sec[i] = '0;
            pwm_t0_sub[i] = '0;
            dir_t0_sec[i] = '0;
            dir_t0_sub[i] = '0;
            fwd_total[i] = '0;
            rev_total[i] = '0;
            width_seen[i] = '0;
        end
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Reset configuration: pwm+dir on both ports, prescaler 255, minimum 50 ms.
        queue_event(1'b0, PIN_PWM, 1'b0, 1'b1, 32'd100, 15'd0);     // falling edge, not armed
        queue_event(1'b0, PIN_PWM, 1'b1, 1'b1, 32'd100, 15'd255);
        queue_event(1'b0, PIN_PWM, 1'b0, 1'b0, 32'd101, 15'd255);   // down count held at zero
        queue_event(1'b0, PIN_PWM, 1'b1, 1'b0, 32'd102, 15'd255);
        queue_event(1'b0, PIN_PWM, 1'b0, 1'b1, 32'd102, 15'd230);   // 97 ms, counts up
        queue_event(1'b0, PIN_PWM, 1'b1, 1'b1, 32'd103, 15'd255);
        queue_event(1'b0, PIN_PWM, 1'b0, 1'b1, 32'd103, 15'd242);   // exactly 50 ms, rejected
        queue_event(1'b0, PIN_PWM, 1'b1, 1'b1, 32'd104, 15'd255);
        queue_event(1'b0, PIN_PWM, 1'b0, 1'b0, 32'd104, 15'd241);   // 54 ms, counts down
        queue_event(1'b0, PIN_DIR, 1'b0, 1'b1, 32'd105, 15'd0);     // dir ignored in this mode
        queue_event(1'b1, PIN_PWM, 1'b1, 1'b1, 32'hFFFF_FFFF, 15'h7FFF);
        queue_event(1'b1, PIN_PWM, 1'b1, 1'b0, 32'hFFFF_FFFF, 15'h7FFF); // arming again
        queue_event(1'b1, PIN_PWM, 1'b0, 1'b1, 32'h0000_0000, 15'h7FFF); // seconds wrap
        queue_event(1'b1, PIN_PWM, 1'b1, 1'b1, 32'd5, 15'd0);
        queue_event(1'b1, PIN_PWM, 1'b0, 1'b1, 32'd4, 15'd255);     // end before start
        wait_for_drain();

        program_regs(MODE_FWD_REV, MODE_FWD_ONLY, 15'd255, 16'd50);
        queue_event(1'b0, PIN_PWM, 1'b1, 1'b0, 32'd200, 15'd255);
        queue_event(1'b0, PIN_DIR, 1'b0, 1'b1, 32'd200, 15'd200);   // dir start drops pwm
        queue_event(1'b0, PIN_PWM, 1'b0, 1'b0, 32'd200, 15'd100);
        queue_event(1'b0, PIN_DIR, 1'b0, 1'b0, 32'd201, 15'd200);   // reverse counted
        queue_event(1'b0, PIN_DIR, 1'b1, 1'b1, 32'd202, 15'd255);
        queue_event(1'b0, PIN_DIR, 1'b1, 1'b0, 32'd202, 15'd250);   // short dir pulse
        queue_event(1'b0, PIN_DIR, 1'b0, 1'b0, 32'd203, 15'd0);     // dir end, not armed
        queue_event(1'b0, PIN_PWM, 1'b1, 1'b1, 32'd204, 15'd255);
        queue_event(1'b0, PIN_PWM, 1'b0, 1'b0, 32'd205, 15'd100);   // forward, reverse kept
        queue_event(1'b1, PIN_PWM, 1'b1, 1'b1, 32'd300, 15'd255);
        queue_event(1'b1, PIN_DIR, 1'b1, 1'b1, 32'd300, 15'd100);
        queue_event(1'b1, PIN_PWM, 1'b0, 1'b0, 32'd301, 15'd0);
        wait_for_drain();

        run_phase(MODE_FWD_REV, MODE_FWD_REV, 15'd255, 16'd50, 21, 125);
        run_phase(MODE_PWM_DIR, MODE_PWM, 15'd0, 16'd0, 21, 125);
        run_phase(MODE_PWM, MODE_FWD_ONLY, 15'h7FFF, 16'hFFFF, 0, 125);
        run_phase(MODE_FWD_REV, MODE_PWM_DIR, 15'd999, 16'd100, 21, 125);
        run_phase(MODE_FWD_ONLY, MODE_FWD_REV, SS_W'($urandom),
                  MINW_W'($urandom_range(300)), 21, 125);
        run_phase(MODE_PWM_DIR, MODE_FWD_REV, 15'd1023, 16'd20, 21, 125);

        repeat (40) @(posedge clk);
        if (bad_results == 0 && counts_due.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// File: qualified_flow_pulse_counter.f
rtl/core/qfpc_pkg.sv
rtl/core/qfpc_div.sv
rtl/core/qfpc_dp.sv
rtl/core/qfpc_ctrl.sv
rtl/core/qualified_flow_pulse_counter.sv
bench/qualified_flow_pulse_counter_tb.sv
